>>> hw/rtl/cash_pkg.sv
`timescale 1ns / 1ps
// Constants and small helpers for the cellular-automaton sponge hash.
// No dependencies; imported by cellular_automaton_sponge_hash_top.
package cash_pkg;

   localparam int LANE_COUNT  = 25;
   localparam int MEM_DEPTH   = 2 * LANE_COUNT;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);
   localparam int GATH_BASE   = LANE_COUNT;
   localparam int ROT_R       = 23;
   localparam int ROT_L       = 3;
   localparam int HASH_W      = 13;
   localparam logic [HASH_W-1:0] HASH_RESET = 13'd256;
   localparam logic [HASH_W-1:0] LEN_MIN    = 13'd128;
   localparam logic [HASH_W-1:0] LEN_MAX    = 13'd4096;
   localparam logic [HASH_W-1:0] CHUNK_BITS = 13'd64;

   typedef logic [2:0]        idx5_type;
   typedef logic [ADDR_W-1:0] addr_type;

   function automatic idx5_type up5(input idx5_type i);
      return (i == 3'd0) ? 3'd4 : 3'(i - 3'd1);
   endfunction

   function automatic idx5_type dn5(input idx5_type i);
      return (i == 3'd4) ? 3'd0 : 3'(i + 3'd1);
   endfunction

   function automatic addr_type lane_addr(input idx5_type r, input idx5_type c);
      return addr_type'({r, 2'b00}) + addr_type'(r) + addr_type'(c);
   endfunction

   // Absorb words per block for a given digest length.
   function automatic logic [4:0] rate_words(input logic [HASH_W-1:0] hb);
      logic [4:0] w;
      unique case (hb)
         13'd224: w = 5'(1152 / 64);
         13'd256: w = 5'(1088 / 64);
         13'd384: w = 5'(832 / 64);
         default: w = 5'(576 / 64);
      endcase
      return w;
   endfunction

   function automatic logic [HASH_W-1:0] sat_len(input logic [HASH_W-1:0] hb);
      logic [HASH_W-1:0] l;
      priority if (hb < LEN_MIN) l = LEN_MIN;
      else if (hb > LEN_MAX)     l = LEN_MAX;
      else                       l = hb;
      return l;
   endfunction

endpackage

>>> hw/rtl/cellular_automaton_sponge_hash_top.sv
`timescale 1ns / 1ps
// Sponge hash with a cellular-automaton permutation, state held in one RAM.
// Depends on cash_pkg.
//
// Usage:
//  req_*  : one padded 64-bit message word per item (first byte in bits 63:56),
//           req_tlast marks the final word and starts the digest output.
//  rsp_*  : digest chunks of 64 bits; rsp_tdata[70:64] gives how many top bits
//           are valid, rsp_tlast marks the final chunk.
//  csr_*  : digest length in bits; a write reloads the initial sponge state.
// Lanes (entries 0..24) and gathered lanes (25..49) share one 50x64 RAM with
// one registered read port and one write port. Absorbing a word reads its
// lane, then writes it back XORed with the word. A permutation runs 17 rule
// passes plus copy, mix and gather sweeps; a block of 9 to 18 words costs one
// permutation, and each digest chunk one permutation. All lane accesses share
// the single RAM read port.
// After reset, after a csr write and after the final chunk, a clearing pass
// writes the initial lanes; req_tready stays low meanwhile.
// A stalled rsp chunk waits in its output register; the next permutation runs
// meanwhile and holds only when the following chunk is ready.
module cellular_automaton_sponge_hash_top
   import cash_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] message_word
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] digest_word, [70:64] valid_bits, [71] zero
   output logic        rsp_tlast,   // digest_last
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data  // hash_bits
);

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_ABS_RD, ST_ABS_WR, ST_PERM, ST_SQ_RD, ST_SQ_OUT
   } st_type;

   typedef enum logic [2:0] {
      OP_R30, OP_MR, OP_R86, OP_ML, OP_R150, OP_GATH, OP_COPY
   } op_type;

   logic [63:0] mem [0:MEM_DEPTH-1];
   logic [63:0] rd_data_ff;

   st_type            state_ff;
   op_type            op_ff;
   logic [HASH_W-1:0] hash_bits_ff;
   logic [HASH_W-1:0] rem_ff;
   logic [4:0]        idx_ff;
   logic [4:0]        pos_ff;
   idx5_type          r_ff, c_ff, ofs_ff;
   logic [2:0]        round_ff;
   logic [2:0]        seq_ff;
   logic              sq_ff, last_ff;
   logic [63:0]       word_ff;
   logic [63:0]       x_ff, n_ff, s_ff, w_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [63:0]       rsp_word_ff;
   logic [6:0]        rsp_bits_ff;

   addr_type    mem_ra, mem_wa;
   logic        mem_we;
   logic [63:0] mem_wd;

   logic [63:0] rule_a, rule_b, rule_y, mix_y;
   logic [4:0]  words;
   logic [4:0]  pos_in;
   idx5_type    gath_r;
   addr_type    gath_wa;
   logic        is_rule, cell_done, op_done;
   logic [63:0] chunk_mask;
   logic        out_free;

   assign words  = rate_words(hash_bits_ff);
   assign pos_in = 5'(pos_ff + 5'd1);

   // Rule over the neighbors; east comes straight from the read port.
   assign rule_a = n_ff ^ w_ff ^ {x_ff[62:0], x_ff[63]};
   assign rule_b = s_ff ^ rd_data_ff ^ {x_ff[0], x_ff[63:1]};
   always_comb begin
      unique case (op_ff)
         OP_R30:  rule_y = rule_a ^ (x_ff | rule_b);
         OP_R86:  rule_y = rule_a | (x_ff ^ rule_b);
         default: rule_y = rule_a ^ x_ff ^ rule_b;
      endcase
   end

   assign mix_y = (op_ff == OP_MR)
                ? rd_data_ff ^ {rd_data_ff[ROT_R-1:0], rd_data_ff[63:ROT_R]}
                : rd_data_ff ^ {rd_data_ff[63-ROT_L:0], rd_data_ff[63:64-ROT_L]};

   // Gathered lanes rotate by offset instead of moving data.
   assign gath_r  = (r_ff >= ofs_ff) ? 3'(r_ff - ofs_ff) : 3'(r_ff + 3'd5 - ofs_ff);
   assign gath_wa = addr_type'(GATH_BASE) + lane_addr(gath_r, 3'(3'd4 - ofs_ff));

   assign is_rule   = (op_ff == OP_R30) || (op_ff == OP_R86) || (op_ff == OP_R150);
   assign cell_done = is_rule ? (seq_ff == 3'd5) : (seq_ff == 3'd1);
   assign op_done   = cell_done && (r_ff == 3'd4) && ((op_ff == OP_GATH) || (c_ff == 3'd4));

   assign chunk_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> rem_ff[5:0]);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      mem_ra = '0;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = addr_type'(idx_ff);
            mem_wd = (idx_ff < words) ? ~(64'd1 << idx_ff) : 64'd0;
         end
         ST_ABS_RD: mem_ra = addr_type'(pos_ff);
         ST_ABS_WR: begin
            mem_we = 1'b1;
            mem_wa = addr_type'(pos_ff);
            mem_wd = rd_data_ff ^ word_ff;
         end
         ST_PERM: begin
            unique case (op_ff)
               OP_R30, OP_R86, OP_R150: begin
                  unique case (seq_ff)
                     3'd1:    mem_ra = lane_addr(up5(r_ff), c_ff);
                     3'd2:    mem_ra = lane_addr(dn5(r_ff), c_ff);
                     3'd3:    mem_ra = lane_addr(r_ff, up5(c_ff));
                     3'd4:    mem_ra = lane_addr(r_ff, dn5(c_ff));
                     default: mem_ra = lane_addr(r_ff, c_ff);
                  endcase
                  mem_we = (seq_ff == 3'd5);
                  mem_wa = lane_addr(r_ff, c_ff);
                  mem_wd = rule_y;
               end
               OP_MR, OP_ML: begin
                  mem_ra = lane_addr(r_ff, c_ff);
                  mem_we = (seq_ff == 3'd1);
                  mem_wa = lane_addr(r_ff, c_ff);
                  mem_wd = mix_y;
               end
               OP_GATH: begin
                  mem_ra = lane_addr(r_ff, 3'd0);
                  mem_we = (seq_ff == 3'd1);
                  mem_wa = gath_wa;
                  mem_wd = rd_data_ff;
               end
               default: begin
                  mem_ra = addr_type'(GATH_BASE) + lane_addr(r_ff, c_ff);
                  mem_we = (seq_ff == 3'd1);
                  mem_wa = lane_addr(r_ff, c_ff);
                  mem_wd = rd_data_ff;
               end
            endcase
         end
         default: mem_ra = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         hash_bits_ff <= HASH_RESET;
         idx_ff       <= '0;
         pos_ff       <= '0;
         sq_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_R30;
         seq_ff       <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         ofs_ff       <= '0;
         round_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               pos_ff <= '0;
               sq_ff  <= 1'b0;
               idx_ff <= 5'(idx_ff + 5'd1);
               if (idx_ff == 5'(LANE_COUNT - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  word_ff  <= req_tdata;
                  last_ff  <= req_tlast;
                  state_ff <= ST_ABS_RD;
               end
            end
            ST_ABS_RD: state_ff <= ST_ABS_WR;
            ST_ABS_WR: begin
               op_ff    <= OP_R30;
               seq_ff   <= '0;
               r_ff     <= '0;
               c_ff     <= '0;
               ofs_ff   <= '0;
               round_ff <= '0;
               if (pos_in >= words) begin
                  pos_ff   <= '0;
                  state_ff <= ST_PERM;
               end else begin
                  pos_ff <= pos_in;
                  if (last_ff) begin
                     sq_ff    <= 1'b1;
                     rem_ff   <= sat_len(hash_bits_ff);
                     state_ff <= ST_PERM;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_PERM: begin
               if (is_rule) begin
                  unique case (seq_ff)
                     3'd1:    x_ff <= rd_data_ff;
                     3'd2:    n_ff <= rd_data_ff;
                     3'd3:    s_ff <= rd_data_ff;
                     3'd4:    w_ff <= rd_data_ff;
                     default: x_ff <= x_ff;
                  endcase
               end
               if (!cell_done) begin
                  seq_ff <= 3'(seq_ff + 3'd1);
               end else begin
                  seq_ff <= '0;
                  if (op_ff == OP_GATH || c_ff == 3'd4) begin
                     c_ff <= '0;
                     r_ff <= (r_ff == 3'd4) ? 3'd0 : 3'(r_ff + 3'd1);
                  end else begin
                     c_ff <= 3'(c_ff + 3'd1);
                  end
               end
               if (op_done) begin
                  unique case (op_ff)
                     OP_R30: op_ff <= OP_MR;
                     OP_MR:  op_ff <= OP_R86;
                     OP_R86: op_ff <= OP_ML;
                     OP_ML:  op_ff <= OP_R150;
                     OP_R150: begin
                        if (round_ff != 3'd5) begin
                           op_ff <= OP_GATH;
                        end else begin
                           op_ff    <= OP_R30;
                           round_ff <= '0;
                           priority if (sq_ff) begin
                              state_ff <= ST_SQ_RD;
                           end else if (last_ff) begin
                              sq_ff    <= 1'b1;
                              rem_ff   <= sat_len(hash_bits_ff);
                           end else begin
                              state_ff <= ST_IDLE;
                           end
                        end
                     end
                     OP_GATH: begin
                        ofs_ff   <= (ofs_ff == 3'd4) ? 3'd0 : 3'(ofs_ff + 3'd1);
                        round_ff <= 3'(round_ff + 3'd1);
                        op_ff    <= (round_ff == 3'd4) ? OP_COPY : OP_R30;
                     end
                     default: op_ff <= OP_R86;
                  endcase
               end
            end
            ST_SQ_RD: state_ff <= ST_SQ_OUT;
            ST_SQ_OUT: begin
               // hold lane (0,0) on the read port until the output register frees
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= (rem_ff <= CHUNK_BITS);
                  if (rem_ff < CHUNK_BITS) begin
                     rsp_word_ff <= rd_data_ff & chunk_mask;
                     rsp_bits_ff <= rem_ff[6:0];
                  end else begin
                     rsp_word_ff <= rd_data_ff;
                     rsp_bits_ff <= 7'd64;
                  end
                  rem_ff <= HASH_W'(rem_ff - CHUNK_BITS);
                  if (rem_ff <= CHUNK_BITS) begin
                     idx_ff   <= '0;
                     state_ff <= ST_INIT;
                  end else begin
                     op_ff    <= OP_R30;
                     seq_ff   <= '0;
                     r_ff     <= '0;
                     c_ff     <= '0;
                     ofs_ff   <= '0;
                     round_ff <= '0;
                     state_ff <= ST_PERM;
                  end
               end
            end
            default: state_ff <= ST_INIT;
         endcase
         // reload the sponge with the new rate
         if (csr_wr_en) begin
            hash_bits_ff <= csr_wr_data;
            idx_ff       <= '0;
            state_ff     <= ST_INIT;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_bits_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_wa_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_wa < addr_type'(MEM_DEPTH)))
      else $error("RAM write beyond the lane store");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mem_we)
      else $error("RAM written while waiting for an item");

   a_perm_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PERM) |-> (r_ff < 3'd5 && c_ff < 3'd5 && ofs_ff < 3'd5 && round_ff < 3'd6))
      else $error("permutation counters out of range");

   a_final_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_OUT && out_free && rem_ff <= CHUNK_BITS && !csr_wr_en)
      |=> (state_ff == ST_INIT && rsp_tlast))
      else $error("final chunk did not restart the sponge");

endmodule

>>> sim/cash_checker.sv
`timescale 1ns / 1ps
// Checker for cellular_automaton_sponge_hash_top: watches req, rsp and csr,
// predicts digest chunks and compares them. Depends on nothing but its ports.
module cash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output int          errors,
   output int          pending
);

   typedef enum int {RULE30, RULE86, RULE150} rule_kind_e;

   typedef struct packed {
      logic [63:0] word;
      logic [6:0]  bits;
      logic        last;
   } chunk_t;

   logic [63:0] lanes  [25];
   logic [63:0] gather [25];
   logic [4:0]  word_pos;
   logic [12:0] digest_len;
   chunk_t      chunk_q[$];

   function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
      return (x << s) | (x >> (64 - s));
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] x, input int s);
      return (x >> s) | (x << (64 - s));
   endfunction

   function automatic int block_words(input logic [12:0] hb);
      case (hb)
         13'd224: return 18;
         13'd256: return 17;
         13'd384: return 13;
         default: return 9;
      endcase
   endfunction

   task automatic clear_sponge();
      for (int k = 0; k < 25; k++) begin
         lanes[k]  = (k < block_words(digest_len)) ? ~(64'd1 << k) : 64'd0;
         gather[k] = '0;
      end
      word_pos = '0;
   endtask

   task automatic apply_rule(input rule_kind_e kind);
      logic [63:0] x, a, b;
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            x = lanes[r*5+c];
            a = lanes[((r+4)%5)*5+c] ^ lanes[r*5+(c+4)%5] ^ rotl(x, 1);
            b = lanes[((r+1)%5)*5+c] ^ lanes[r*5+(c+1)%5] ^ rotr(x, 1);
            case (kind)
               RULE30:  lanes[r*5+c] = a ^ (x | b);
               RULE86:  lanes[r*5+c] = a | (x ^ b);
               default: lanes[r*5+c] = a ^ x ^ b;
            endcase
         end
      end
   endtask

   task automatic mix_lanes(input bit left3);
      for (int k = 0; k < 25; k++)
         lanes[k] ^= left3 ? rotl(lanes[k], 3) : rotr(lanes[k], 23);
   endtask

   task automatic permute_sponge();
      logic [63:0] tmp [25];
      for (int k = 0; k < 25; k++) gather[k] = '0;
      for (int i = 0; i < 5; i++) begin
         apply_rule(RULE30);
         mix_lanes(1'b0);
         apply_rule(RULE86);
         mix_lanes(1'b1);
         apply_rule(RULE150);
         for (int r = 0; r < 5; r++) gather[r*5+4] = lanes[r*5];
         tmp = gather;
         // shift one row down and one column right, wrapping
         for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
               gather[r*5+c] = tmp[((r+4)%5)*5+(c+4)%5];
      end
      lanes = gather;
      apply_rule(RULE86);
      mix_lanes(1'b1);
      apply_rule(RULE150);
   endtask

   task automatic absorb_word(input logic [63:0] d, input logic fin);
      int     len;
      chunk_t ch;
      lanes[word_pos % 25] ^= d;
      word_pos = word_pos + 5'd1;
      if (word_pos >= block_words(digest_len)) begin
         permute_sponge();
         word_pos = '0;
      end
      if (!fin) return;
      len = (digest_len < 128) ? 128 : (digest_len > 4096) ? 4096 : digest_len;
      for (int done = 0; done < len; done += 64) begin
         permute_sponge();
         ch.word = lanes[0];
         ch.bits = (len - done < 64) ? 7'(len - done) : 7'd64;
         if (ch.bits != 7'd64) ch.word &= ~({64{1'b1}} >> ch.bits);
         ch.last = (done + 64 >= len);
         chunk_q.push_back(ch);
      end
      clear_sponge();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      errors++;
   endtask

   initial begin
      errors = 0;
      digest_len = 13'd256;
      clear_sponge();
   end

   always @(posedge clock) begin
      chunk_t want;
      if (reset) begin
         digest_len = 13'd256;
         clear_sponge();
         chunk_q.delete();
      end else begin
         if (csr_wr_en) begin
            digest_len = csr_wr_data;
            clear_sponge();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (chunk_q.size() == 0) begin
               report_mismatch("unexpected chunk", rsp_tdata[63:0], '0);
            end else begin
               want = chunk_q.pop_front();
               if (rsp_tdata[63:0] !== want.word)
                  report_mismatch("digest_word", rsp_tdata[63:0], want.word);
               if (rsp_tdata[70:64] !== want.bits)
                  report_mismatch("valid_bits", rsp_tdata[70:64], want.bits);
               if (rsp_tdata[71] !== 1'b0)
                  report_mismatch("pad bit", rsp_tdata[71], 0);
               if (rsp_tlast !== want.last)
                  report_mismatch("digest_last", rsp_tlast, want.last);
            end
         end
         if (req_tvalid && req_tready) absorb_word(req_tdata, req_tlast);
      end
      pending = chunk_q.size();
   end

endmodule

>>> sim/tb_cellular_automaton_sponge_hash_top.sv
`timescale 1ns / 1ps
// Testbench top for cellular_automaton_sponge_hash_top: drives message words,
// digest lengths and backpressure. Depends on cash_checker and the RTL.
module tb_cellular_automaton_sponge_hash_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;
   int          errors;
   int          pending;
   bit          req_busy;
   bit          rsp_busy;
   bit          long_hold;

   always #5 clock = ~clock;

   cellular_automaton_sponge_hash_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   cash_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .errors(errors), .pending(pending)
   );

   task automatic send_word(input logic [63:0] d, input logic fin);
      int gap;
      gap = req_busy ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= fin;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
   endtask

   task automatic send_message(input int words);
      logic [63:0] d;
      for (int i = 0; i < words; i++) begin
         d = {$urandom, $urandom};
         send_word(d, i == words - 1);
      end
   endtask

   // drain results, then let the clearing pass or a trailing permutation finish
   task automatic settle();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4000) @(posedge clock);
   endtask

   task automatic set_digest_len(input logic [12:0] hb);
      settle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= hb;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // receiver: random stalls, bursts, and one long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (8000) @(posedge clock);
         end
         gap = rsp_busy ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         forever begin
            @(negedge clock);
            if (rsp_tvalid || long_hold) break;
         end
         @(posedge clock);
      end
   end

   initial begin
      int sent;
      int len;
      req_busy = 1'b1;
      rsp_busy = 1'b1;
      long_hold = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default length: extremes of the word, last word in a partial block
      send_word('1, 1'b0);
      send_word('0, 1'b1);
      set_digest_len(13'd224);
      send_word(64'h5555_5555_5555_5555, 1'b1);
      set_digest_len(13'd384);
      send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      // below range: 128 bits, rate 576, message exactly one block
      set_digest_len(13'd0);
      for (int i = 0; i < 9; i++) send_word({$urandom, $urandom}, i == 8);
      // above range: saturates to 4096, 64 chunks
      set_digest_len(13'h1FFF);
      send_word(64'h8000_0000_0000_0001, 1'b1);
      // truncated final chunk
      set_digest_len(13'd200);
      send_word(64'h0123_4567_89AB_CDEF, 1'b1);

      sent = 0;
      for (int ph = 0; sent < 300; ph++) begin
         case (ph % 6)
            0: set_digest_len(13'd224);
            1: set_digest_len(13'd256);
            2: set_digest_len(13'd384);
            3: set_digest_len(13'd128);
            4: set_digest_len(13'd4096);
            default: set_digest_len(13'($urandom_range(100, 400)));
         endcase
         req_busy = ($urandom_range(0, 3) != 0);
         rsp_busy = ($urandom_range(0, 3) != 0);
         if (ph == 2) long_hold = 1'b1;
         if (ph % 6 == 4) begin
            send_message(2);
            sent += 2;
         end else begin
            for (int m = 0; m < 4; m++) begin
               len = $urandom_range(1, 24);
               send_message(len);
               sent += len;
            end
         end
      end
      req_busy = 1'b1;
      rsp_busy = 1'b1;
      settle();
      if (errors == 0)
         $display("PASS cellular_automaton_sponge_hash_top");
      else
         $display("FAIL cellular_automaton_sponge_hash_top");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("FAIL cellular_automaton_sponge_hash_top");
      $finish;
   end

endmodule

>>> cellular_automaton_sponge_hash_top.f
hw/rtl/cash_pkg.sv
hw/rtl/cellular_automaton_sponge_hash_top.sv
sim/cash_checker.sv
sim/tb_cellular_automaton_sponge_hash_top.sv
